>>> design/mmq_pkg.sv
`default_nettype none

package mmq_pkg;

   localparam int MAILBOXES  = 8;
   localparam int POOL_SIZE  = 64;
   localparam int WORD_WIDTH = 32;
   localparam int MBX_W      = $clog2(MAILBOXES);
   localparam int MBX_PTR_W  = $clog2(MAILBOXES + 1);
   localparam int IDX_W      = $clog2(POOL_SIZE);
   localparam int PTR_W      = $clog2(POOL_SIZE + 1);
   localparam int CNT_W      = 7;
   localparam int OWNER_W    = 4;
   localparam int MISSED_W   = 16;
   localparam int POLICY_W   = 2;
   localparam int ACTION_W   = 3;
   localparam int STATUS_W   = 3;

   localparam logic [PTR_W-1:0]     NIL_MSG       = PTR_W'(POOL_SIZE);
   localparam logic [MBX_PTR_W-1:0] NIL_MBX       = MBX_PTR_W'(MAILBOXES);
   localparam logic [CNT_W-1:0]     DEFAULT_LIMIT = CNT_W'(8);
   localparam logic [CNT_W-1:0]     POOL_LIMIT    = CNT_W'(POOL_SIZE);

   typedef enum logic [ACTION_W-1:0] {
      ACT_SEND  = 3'd0,
      ACT_RECV  = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_SETPOL = 3'd3,
      ACT_ALLOC = 3'd4,
      ACT_FREE  = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_ARG        = 3'd1,
      ST_NOT_ALLOC  = 3'd2,
      ST_POOL_EMPTY = 3'd3,
      ST_QUEUE_FULL = 3'd4,
      ST_NO_MSG     = 3'd5,
      ST_NOT_OWNER  = 3'd6,
      ST_NO_MBX     = 3'd7
   } status_type;

   typedef enum logic [POLICY_W-1:0] {
      POL_UNLIMITED = 2'd0,
      POL_NEWEST    = 2'd1,
      POL_OLDEST    = 2'd2
   } policy_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CHECK,
      CMD_TAKE,
      CMD_LINK,
      CMD_RD_HEAD,
      CMD_POP,
      CMD_POP_DROP,
      CMD_WALK_INIT,
      CMD_WALK_STEP,
      CMD_CUT,
      CMD_REL_TAIL,
      CMD_RX_DATA,
      CMD_FREE_DONE,
      CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      logic                early_bad;
      logic [ACTION_W-1:0] action;
      logic                newest;
      logic                oldest;
      logic                reject;
      logic                over;
      logic                count_le1;
      logic                count_zero;
      logic                walk_hit;
      logic                out_busy;
   } dp_status_type;

   typedef struct packed {
      logic [ACTION_W-1:0]          action;
      logic [MBX_W-1:0]             mailbox;
      logic [OWNER_W-1:0]           requester;
      logic signed [WORD_WIDTH-1:0] word_a;
      logic signed [WORD_WIDTH-1:0] word_b;
      logic signed [WORD_WIDTH-1:0] word_c;
      logic [POLICY_W-1:0]          new_policy;
      logic [CNT_W-1:0]             new_limit;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0]          status;
      logic signed [WORD_WIDTH-1:0] out_word_a;
      logic signed [WORD_WIDTH-1:0] out_word_b;
      logic signed [WORD_WIDTH-1:0] out_word_c;
      logic [MBX_W-1:0]             granted_mailbox;
      logic [CNT_W-1:0]             queued_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> design/mmq_chan_if.sv
`default_nettype none

interface mmq_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/mmq_dp.sv
`default_nettype none

module mmq_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  mmq_pkg::dp_cmd_type      cmd,
   input  mmq_pkg::req_payload_type req_payload,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output mmq_pkg::rsp_payload_type rsp_payload,
   output mmq_pkg::dp_status_type   dp_status
);
   import mmq_pkg::*;

   localparam int WORDS_W = 3 * WORD_WIDTH;

   // request and working registers
   req_payload_type req_ff, req_in;
   status_type      status_ff, status_in;
   logic [WORDS_W-1:0] rx_words_ff, rx_words_in;
   logic [MBX_W-1:0]   granted_ff, granted_in;
   logic [PTR_W-1:0]   b_ff, b_in;
   logic [PTR_W-1:0]   p_ff, p_in;

   // message pool
   logic [WORDS_W-1:0] words_mem [POOL_SIZE];
   logic [WORDS_W-1:0] words_rd_ff;
   logic               words_we;
   logic               words_re;
   logic [IDX_W-1:0]   words_addr;
   logic [PTR_W-1:0]   next_mem [POOL_SIZE];
   logic [PTR_W-1:0]   next_rd_ff;
   logic               next_rd_vld_ff;
   logic [IDX_W-1:0]   next_rd_addr_ff;
   logic [POOL_SIZE-1:0] next_vld_ff, next_vld_in;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [PTR_W-1:0]   wr_data;
   logic [PTR_W-1:0]   rd_next;

   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;

   // mailbox table
   logic [PTR_W-1:0]     q_head_ff [MAILBOXES];
   logic [PTR_W-1:0]     q_head_in [MAILBOXES];
   logic [PTR_W-1:0]     q_tail_ff [MAILBOXES];
   logic [PTR_W-1:0]     q_tail_in [MAILBOXES];
   logic [CNT_W-1:0]     q_count_ff [MAILBOXES];
   logic [CNT_W-1:0]     q_count_in [MAILBOXES];
   logic [CNT_W-1:0]     q_limit_ff [MAILBOXES];
   logic [CNT_W-1:0]     q_limit_in [MAILBOXES];
   logic [POLICY_W-1:0]  q_policy_ff [MAILBOXES];
   logic [POLICY_W-1:0]  q_policy_in [MAILBOXES];
   logic [MISSED_W-1:0]  missed_ff [MAILBOXES];
   logic [MISSED_W-1:0]  missed_in [MAILBOXES];
   logic [OWNER_W-1:0]   owner_ff [MAILBOXES];
   logic [OWNER_W-1:0]   owner_in [MAILBOXES];
   logic [MAILBOXES-1:0] in_use_ff, in_use_in;
   logic [MBX_PTR_W-1:0] mbx_next_ff [MAILBOXES];
   logic [MBX_PTR_W-1:0] mbx_next_in [MAILBOXES];
   logic [MBX_PTR_W-1:0] free_mbx_ff, free_mbx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic [MBX_W-1:0]    m;
   logic [ACTION_W-1:0] act;
   logic [PTR_W-1:0]    cur_head;
   logic [PTR_W-1:0]    cur_tail;
   logic [CNT_W-1:0]    cur_count;
   logic [CNT_W-1:0]    cur_limit;
   logic [MISSED_W-1:0] cur_missed;
   logic [MBX_W-1:0]    alloc_mbx;
   status_type          early_st;
   logic                reject;
   logic                do_pop;
   logic                do_bump;
   logic                out_busy;

   assign m          = req_ff.mailbox;
   assign act        = req_ff.action;
   assign cur_head   = q_head_ff[m];
   assign cur_tail   = q_tail_ff[m];
   assign cur_count  = q_count_ff[m];
   assign cur_limit  = q_limit_ff[m];
   assign cur_missed = missed_ff[m];
   assign alloc_mbx  = free_mbx_ff[MBX_W-1:0];
   assign reject     = (q_policy_ff[m] == POL_OLDEST) && (cur_count >= cur_limit);
   assign out_busy   = rsp_valid_ff && !rsp_ready;
   // a link never written still holds its reset chain value
   assign rd_next    = next_rd_vld_ff ? next_rd_ff
                                      : PTR_W'(next_rd_addr_ff) + PTR_W'(1);

   always_comb begin
      early_st = ST_OK;
      if (act == ACT_ALLOC) begin
         if (free_mbx_ff == NIL_MBX) early_st = ST_NO_MBX;
      end else if (act > ACT_FREE) begin
         early_st = ST_ARG;
      end else if (act == ACT_SETPOL && req_ff.new_policy > POL_OLDEST) begin
         early_st = ST_ARG;
      end else if (!in_use_ff[m]) begin
         early_st = ST_NOT_ALLOC;
      end else if ((act == ACT_SETPOL || act == ACT_FREE) && req_ff.requester != '0
                   && owner_ff[m] != req_ff.requester) begin
         early_st = ST_NOT_OWNER;
      end else if (act == ACT_SEND && free_count_ff == '0) begin
         early_st = ST_POOL_EMPTY;
      end else if ((act == ACT_RECV || act == ACT_PEEK) && cur_count == '0) begin
         early_st = ST_NO_MSG;
      end
   end

   always_comb begin
      dp_status.early_bad  = (early_st != ST_OK);
      dp_status.action     = act;
      dp_status.newest     = (q_policy_ff[m] == POL_NEWEST);
      dp_status.oldest     = (q_policy_ff[m] == POL_OLDEST);
      dp_status.reject     = reject;
      dp_status.over       = (cur_count > cur_limit);
      dp_status.count_le1  = (cur_count <= CNT_W'(1));
      dp_status.count_zero = (cur_count == '0);
      dp_status.walk_hit   = (rd_next == cur_tail);
      dp_status.out_busy   = out_busy;
   end

   always_comb begin
      req_in        = req_ff;
      status_in     = status_ff;
      rx_words_in   = rx_words_ff;
      granted_in    = granted_ff;
      b_in          = b_ff;
      p_in          = p_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      q_head_in     = q_head_ff;
      q_tail_in     = q_tail_ff;
      q_count_in    = q_count_ff;
      q_limit_in    = q_limit_ff;
      q_policy_in   = q_policy_ff;
      missed_in     = missed_ff;
      owner_in      = owner_ff;
      in_use_in     = in_use_ff;
      mbx_next_in   = mbx_next_ff;
      free_mbx_in   = free_mbx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = cur_head[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = b_ff[IDX_W-1:0];
      wr_data       = NIL_MSG;
      words_we      = 1'b0;
      words_re      = 1'b0;
      words_addr    = cur_head[IDX_W-1:0];
      do_pop        = 1'b0;
      do_bump       = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (cmd)
         CMD_LOAD: begin
            req_in      = req_payload;
            status_in   = ST_OK;
            rx_words_in = '0;
            granted_in  = '0;
         end
         CMD_CHECK: begin
            status_in = early_st;
            if (early_st == ST_OK) begin
               if (act == ACT_ALLOC) begin
                  free_mbx_in            = mbx_next_ff[alloc_mbx];
                  mbx_next_in[alloc_mbx] = NIL_MBX;
                  owner_in[alloc_mbx]    = req_ff.requester;
                  in_use_in[alloc_mbx]   = 1'b1;
                  q_head_in[alloc_mbx]   = NIL_MSG;
                  q_tail_in[alloc_mbx]   = NIL_MSG;
                  q_count_in[alloc_mbx]  = '0;
                  missed_in[alloc_mbx]   = '0;
                  q_limit_in[alloc_mbx]  = DEFAULT_LIMIT;
                  q_policy_in[alloc_mbx] = POL_NEWEST;
                  granted_in             = alloc_mbx;
               end else if (act == ACT_SETPOL) begin
                  q_policy_in[m] = req_ff.new_policy;
                  q_limit_in[m]  = (req_ff.new_limit > POOL_LIMIT) ? POOL_LIMIT
                                                                   : req_ff.new_limit;
               end else if (act == ACT_SEND) begin
                  b_in       = free_head_ff;
                  rd_en      = 1'b1;
                  rd_addr    = free_head_ff[IDX_W-1:0];
                  words_we   = 1'b1;
                  words_addr = free_head_ff[IDX_W-1:0];
               end else if (act == ACT_RECV || act == ACT_PEEK) begin
                  rd_en    = 1'b1;
                  words_re = 1'b1;
               end
            end
         end
         CMD_TAKE: begin
            if (reject) begin
               do_bump = 1'b1;
            end else begin
               free_head_in  = rd_next;
               free_count_in = free_count_ff - CNT_W'(1);
               wr_en         = 1'b1;
               wr_data       = NIL_MSG;
            end
         end
         CMD_LINK: begin
            if (cur_tail != NIL_MSG) begin
               wr_en   = 1'b1;
               wr_addr = cur_tail[IDX_W-1:0];
               wr_data = b_ff;
            end else begin
               q_head_in[m] = b_ff;
            end
            q_tail_in[m]  = b_ff;
            q_count_in[m] = cur_count + CNT_W'(1);
         end
         CMD_RD_HEAD: begin
            rd_en = 1'b1;
         end
         CMD_POP: begin
            do_pop = 1'b1;
         end
         CMD_POP_DROP: begin
            do_pop  = 1'b1;
            do_bump = 1'b1;
         end
         CMD_WALK_INIT: begin
            p_in  = cur_head;
            rd_en = 1'b1;
         end
         CMD_WALK_STEP: begin
            p_in    = rd_next;
            rd_en   = 1'b1;
            rd_addr = rd_next[IDX_W-1:0];
         end
         CMD_CUT: begin
            wr_en         = 1'b1;
            wr_addr       = p_ff[IDX_W-1:0];
            wr_data       = NIL_MSG;
            b_in          = cur_tail;
            q_tail_in[m]  = p_ff;
            q_count_in[m] = cur_count - CNT_W'(1);
         end
         CMD_REL_TAIL: begin
            wr_en         = 1'b1;
            wr_data       = free_head_ff;
            free_head_in  = b_ff;
            free_count_in = free_count_ff + CNT_W'(1);
            do_bump       = 1'b1;
         end
         CMD_RX_DATA: begin
            rx_words_in = words_rd_ff;
            do_pop      = (act == ACT_RECV);
         end
         CMD_FREE_DONE: begin
            q_count_in[m]  = '0;
            q_head_in[m]   = NIL_MSG;
            q_tail_in[m]   = NIL_MSG;
            in_use_in[m]   = 1'b0;
            mbx_next_in[m] = free_mbx_ff;
            free_mbx_in    = MBX_PTR_W'(m);
         end
         CMD_EMIT: begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = status_ff;
            rsp_in.out_word_a      = rx_words_ff[3*WORD_WIDTH-1:2*WORD_WIDTH];
            rsp_in.out_word_b      = rx_words_ff[2*WORD_WIDTH-1:WORD_WIDTH];
            rsp_in.out_word_c      = rx_words_ff[WORD_WIDTH-1:0];
            rsp_in.granted_mailbox = granted_ff;
            rsp_in.queued_count    = (act <= ACT_FREE && act != ACT_ALLOC) ? cur_count
                                                                          : '0;
         end
         default: begin
         end
      endcase

      if (do_pop) begin
         q_head_in[m] = rd_next;
         if (rd_next == NIL_MSG) q_tail_in[m] = NIL_MSG;
         q_count_in[m] = cur_count - CNT_W'(1);
         wr_en         = 1'b1;
         wr_addr       = cur_head[IDX_W-1:0];
         wr_data       = free_head_ff;
         free_head_in  = cur_head;
         free_count_in = free_count_ff + CNT_W'(1);
      end
      if (do_bump) begin
         status_in = ST_QUEUE_FULL;
         if (cur_missed != '1) missed_in[m] = cur_missed + MISSED_W'(1);
      end

      next_vld_in = next_vld_ff;
      if (wr_en) next_vld_in[wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (words_we) words_mem[words_addr] <= {req_ff.word_a, req_ff.word_b, req_ff.word_c};
      if (words_re) words_rd_ff <= words_mem[words_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) next_mem[wr_addr] <= wr_data;
      if (rd_en) begin
         next_rd_ff      <= next_mem[rd_addr];
         next_rd_vld_ff  <= next_vld_ff[rd_addr];
         next_rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      status_ff   <= status_in;
      rx_words_ff <= rx_words_in;
      granted_ff  <= granted_in;
      b_ff        <= b_in;
      p_ff        <= p_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff   <= '0;
         free_head_ff  <= '0;
         free_count_ff <= POOL_LIMIT;
         in_use_ff     <= '0;
         free_mbx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAILBOXES; i++) begin
            q_head_ff[i]   <= NIL_MSG;
            q_tail_ff[i]   <= NIL_MSG;
            q_count_ff[i]  <= '0;
            q_limit_ff[i]  <= DEFAULT_LIMIT;
            q_policy_ff[i] <= POL_NEWEST;
            missed_ff[i]   <= '0;
            owner_ff[i]    <= '0;
            mbx_next_ff[i] <= MBX_PTR_W'(i + 1);
         end
      end else begin
         next_vld_ff   <= next_vld_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         in_use_ff     <= in_use_in;
         free_mbx_ff   <= free_mbx_in;
         rsp_valid_ff  <= rsp_valid_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         q_count_ff    <= q_count_in;
         q_limit_ff    <= q_limit_in;
         q_policy_ff   <= q_policy_in;
         missed_ff     <= missed_in;
         owner_ff      <= owner_in;
         mbx_next_ff   <= mbx_next_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_free_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= POOL_LIMIT)
      else $error("free block count above pool size");

   a_free_list_empty: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff == '0) == (free_head_ff == NIL_MSG))
      else $error("free block count and free list head disagree");

   a_free_mbx_unused: assert property (@(posedge clock) disable iff (reset)
      (free_mbx_ff != NIL_MBX) |-> !in_use_ff[alloc_mbx])
      else $error("mailbox on free list is in use");

endmodule

`default_nettype wire

>>> design/mmq_ctrl.sv
`default_nettype none

module mmq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mmq_pkg::dp_status_type dp_status,
   output mmq_pkg::dp_cmd_type    cmd
);
   import mmq_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_TAKE,
      S_LINK,
      S_NEW_CHK,
      S_OLD_CHK,
      S_POP_RD,
      S_POP,
      S_WALK_CMP,
      S_REL_TAIL,
      S_RX_DATA,
      S_FREE_CHK,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_NEWEST,
      MODE_OLDEST,
      MODE_FREE
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd = CMD_CHECK;
            if (dp_status.early_bad || dp_status.action == ACT_ALLOC
                || dp_status.action == ACT_SETPOL) begin
               state_in = S_FINISH;
            end else if (dp_status.action == ACT_SEND) begin
               state_in = S_TAKE;
            end else if (dp_status.action == ACT_RECV || dp_status.action == ACT_PEEK) begin
               state_in = S_RX_DATA;
            end else begin
               state_in = S_FREE_CHK;
            end
         end
         S_TAKE: begin
            cmd      = CMD_TAKE;
            state_in = dp_status.reject ? S_OLD_CHK : S_LINK;
         end
         S_LINK: begin
            cmd = CMD_LINK;
            if (dp_status.newest) state_in = S_NEW_CHK;
            else if (dp_status.oldest) state_in = S_OLD_CHK;
            else state_in = S_FINISH;
         end
         S_NEW_CHK: begin
            if (dp_status.over) begin
               mode_in  = MODE_NEWEST;
               state_in = S_POP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_OLD_CHK: begin
            if (!dp_status.over) begin
               state_in = S_FINISH;
            end else if (dp_status.count_le1) begin
               mode_in  = MODE_OLDEST;
               state_in = S_POP_RD;
            end else begin
               cmd      = CMD_WALK_INIT;
               state_in = S_WALK_CMP;
            end
         end
         S_POP_RD: begin
            cmd      = CMD_RD_HEAD;
            state_in = S_POP;
         end
         S_POP: begin
            cmd = (mode_ff == MODE_FREE) ? CMD_POP : CMD_POP_DROP;
            unique case (mode_ff)
               MODE_NEWEST: state_in = S_NEW_CHK;
               MODE_OLDEST: state_in = S_OLD_CHK;
               default:     state_in = S_FREE_CHK;
            endcase
         end
         S_WALK_CMP: begin
            if (dp_status.walk_hit) begin
               cmd      = CMD_CUT;
               state_in = S_REL_TAIL;
            end else begin
               cmd = CMD_WALK_STEP;
            end
         end
         S_REL_TAIL: begin
            cmd      = CMD_REL_TAIL;
            state_in = S_OLD_CHK;
         end
         S_RX_DATA: begin
            cmd      = CMD_RX_DATA;
            state_in = S_FINISH;
         end
         S_FREE_CHK: begin
            if (dp_status.count_zero) begin
               cmd      = CMD_FREE_DONE;
               state_in = S_FINISH;
            end else begin
               mode_in  = MODE_FREE;
               state_in = S_POP_RD;
            end
         end
         S_FINISH: begin
            if (!dp_status.out_busy) begin
               cmd      = CMD_EMIT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_NEWEST;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

`default_nettype wire

>>> design/mailbox_message_queue.sv
// Mailbox message queue: a pool of 64 three-word message blocks shared by 8
// mailboxes, each a linked FIFO with its own limit and overflow policy. One
// request gives exactly one response. A request is accepted in the idle state
// and checked in the check state; allocate, set policy and every request that
// fails the check then go to the finish state. Peek and receive read the data
// first; a send takes a block and links it, then under keep newest drops head
// messages while over the limit. Under keep oldest each message trimmed from
// the tail costs a walk along the queue, since the link table has one read
// port and the tail's predecessor is found by walking from the head. Free
// mailbox pops every queued message. A new request is taken once the previous
// one has been placed in the response register, even while that response waits.
`default_nettype none

module mailbox_message_queue (
   input  logic clock,
   input  logic reset,
   mmq_chan_if.sink   req_bus,
   mmq_chan_if.source rsp_bus
);
   import mmq_pkg::*;

   dp_cmd_type      cmd;
   dp_status_type   dp_status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   assign req_payload   = req_bus.payload;
   assign req_bus.ready = req_ready;
   assign rsp_bus.valid   = rsp_valid;
   assign rsp_bus.payload = rsp_payload;

   mmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   mmq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .dp_status   (dp_status)
   );

endmodule

`default_nettype wire
